// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse
// Element count, queue depth and register map of the configuration port.
// ----------------------------------------------------------------------------
package mi3_pkg;

   // elements of one 3x3 matrix
   localparam int NUM_ELEMS = 9;

   // entries in the queue between classification and division
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   typedef enum logic [0:0] {
      REG_SINGULAR_THRESHOLD = 1'b0
   } reg_index_type;

endpackage

// ===== rtl/mi3_queue.sv =====
// ----------------------------------------------------------------------------
// mi3_queue: short FIFO between the front and back pipelines
// Holds classified requests so either side can stall on its own.
// ----------------------------------------------------------------------------
module mi3_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);

   localparam int PW = $clog2(mi3_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(mi3_pkg::QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [mi3_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CW'(mi3_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and level update
   always_comb begin
      wr_ptr_in = do_push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front: cofactors, determinant and singular classification
// Five stages: products, cofactors, partial products of the determinant,
// determinant sum, then magnitude, threshold compare and output format.
// ----------------------------------------------------------------------------
module mi3_front #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          advance,
   input  logic                                          in_valid,
   input  logic [mi3_pkg::NUM_ELEMS*ELEMENT_WIDTH-1:0]   in_elems,
   input  logic [30:0]                                   threshold,
   output logic                                          out_valid,
   output logic [9*(2*ELEMENT_WIDTH+1)+9+3*ELEMENT_WIDTH+3+1+ELEMENT_WIDTH-1:0]
                                                         out_entry
);

   localparam int W  = ELEMENT_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int PW = 2 * W;          // element product
   localparam int AW = 2 * W + 1;      // cofactor
   localparam int DW = 3 * W + 3;      // determinant
   localparam int CW = DW + 2 * F + 32; // threshold compare width
   localparam int N  = mi3_pkg::NUM_ELEMS;

   // stage 1: element products
   logic signed [PW-1:0] p0_ff [N];
   logic signed [PW-1:0] p1_ff [N];
   logic signed [W-1:0]  row0_1_ff [3];
   logic                 v1_ff;
   // stage 2: cofactors
   logic signed [AW-1:0] adj2_ff [N];
   logic signed [W-1:0]  row0_2_ff [3];
   logic                 v2_ff;
   // stage 3: determinant partial products
   logic signed [AW-1:0] pl_ff [3];
   logic signed [AW-1:0] ph_ff [3];
   logic signed [AW-1:0] adj3_ff [N];
   logic                 v3_ff;
   // stage 4: determinant
   logic signed [DW-1:0] det_ff, det_in;
   logic signed [AW-1:0] adj4_ff [N];
   logic                 v4_ff;
   // stage 5: classification
   logic [AW-1:0]        mag5_ff [N];
   logic [N-1:0]         neg5_ff;
   logic [DW-1:0]        dmag5_ff, dmag_in;
   logic                 sing5_ff, sing_in;
   logic [W-1:0]         dval5_ff, dval_in;
   logic                 v5_ff;

   logic signed [W-1:0]  m [N];
   logic [DW-1:0]        dshift;
   logic                 dneg;

   always_comb begin
      for (int k = 0; k < N; k++) begin
         m[k] = in_elems[k*W +: W];
      end
   end

   // cofactor products: adj[i][j] = m[j+1][i+1]*m[j+2][i+2] - m[j+1][i+2]*m[j+2][i+1]
   for (genvar gi = 0; gi < 3; gi++) begin : g_row
      for (genvar gj = 0; gj < 3; gj++) begin : g_col
         localparam int A = ((gj + 1) % 3) * 3 + (gi + 1) % 3;
         localparam int B = ((gj + 2) % 3) * 3 + (gi + 2) % 3;
         localparam int C = ((gj + 1) % 3) * 3 + (gi + 2) % 3;
         localparam int D = ((gj + 2) % 3) * 3 + (gi + 1) % 3;
         always_ff @(posedge clock) begin
            if (advance) begin
               p0_ff[gi*3+gj] <= m[A] * m[B];
               p1_ff[gi*3+gj] <= m[C] * m[D];
            end
         end
      end
   end

   // stages 1..4 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            row0_1_ff[k] <= m[k];
            row0_2_ff[k] <= row0_1_ff[k];
         end
         for (int k = 0; k < N; k++) begin
            adj2_ff[k] <= AW'(p0_ff[k]) - AW'(p1_ff[k]);
            adj3_ff[k] <= adj2_ff[k];
            adj4_ff[k] <= adj3_ff[k];
         end
         // det term j = m[0][j] * adj[j][0], adj split into low and high halves
         for (int k = 0; k < 3; k++) begin
            pl_ff[k] <= row0_2_ff[k] * $signed({1'b0, adj2_ff[k*3][W-1:0]});
            ph_ff[k] <= row0_2_ff[k] * $signed(adj2_ff[k*3][AW-1:W]);
         end
         det_ff <= det_in;
      end
   end

   // determinant sum
   always_comb begin
      det_in = '0;
      for (int k = 0; k < 3; k++) begin
         det_in = det_in + (DW'(ph_ff[k]) <<< W) + DW'(pl_ff[k]);
      end
   end

   // magnitude, threshold compare, determinant output format
   always_comb begin
      dneg    = det_ff[DW-1];
      dmag_in = dneg ? DW'(-det_ff) : DW'(det_ff);
      sing_in = (CW'(dmag_in) <= (CW'(threshold) << (2 * F))) || (dmag_in == '0);
      dshift  = dmag_in >> (2 * F);
      dval_in = dneg ? W'(-dshift) : dshift[W-1:0];
      if (dneg && (dshift > (DW'(1) << (W - 1)))) begin
         dval_in = {1'b1, {(W-1){1'b0}}};
      end else if (!dneg && (dshift > ((DW'(1) << (W - 1)) - 1'b1))) begin
         dval_in = {1'b0, {(W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N; k++) begin
            mag5_ff[k] <= adj4_ff[k][AW-1] ? AW'(-adj4_ff[k]) : AW'(adj4_ff[k]);
            neg5_ff[k] <= adj4_ff[k][AW-1] ^ det_ff[DW-1];
         end
         dmag5_ff <= dmag_in;
         sing5_ff <= sing_in;
         dval5_ff <= dval_in;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // pack: cofactor magnitudes, signs, det magnitude, singular, det value
   always_comb begin
      for (int k = 0; k < N; k++) begin
         out_entry[k*AW +: AW] = mag5_ff[k];
      end
      out_entry[N*AW +: N]              = neg5_ff;
      out_entry[N*AW+N +: DW]           = dmag5_ff;
      out_entry[N*AW+N+DW]              = sing5_ff;
      out_entry[N*AW+N+DW+1 +: W]       = dval5_ff;
   end

   assign out_valid = v5_ff;

endmodule

// ===== rtl/mi3_back.sv =====
// ----------------------------------------------------------------------------
// mi3_back: pipelined restoring division and output register
// Nine lanes, one quotient bit per stage, saturation and identity select.
// ----------------------------------------------------------------------------
module mi3_back #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [9*(2*ELEMENT_WIDTH+1)+9+3*ELEMENT_WIDTH+3+1+ELEMENT_WIDTH-1:0]
                                         in_entry,
   output logic                          advance,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ELEMENT_WIDTH-1:0]      out_elems [mi3_pkg::NUM_ELEMS],
   output logic [ELEMENT_WIDTH-1:0]      out_det,
   output logic                          out_singular
);

   localparam int W  = ELEMENT_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int AW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int XW = 4 * W + 2 * F + 1;
   localparam int N  = mi3_pkg::NUM_ELEMS;
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ONE_VAL = (F >= W - 1) ? MAX_VAL : (W'(1) << F);

   logic [XW-1:0]  rem_ff  [W][N];
   logic [W-2:0]   quo_ff  [W][N];
   logic           ovf_ff  [W][N];
   logic           neg_ff  [W][N];
   logic [DW-1:0]  dmag_ff [W];
   logic           sing_ff [W];
   logic [W-1:0]   dval_ff [W];
   logic [W-1:0]   v_ff;

   logic [W-1:0]   res_ff [N];
   logic [W-1:0]   det_ff;
   logic           sout_ff;
   logic           ovalid_ff;

   logic [DW-1:0]  in_dmag;
   logic [XW-1:0]  in_num [N];

   assign advance = !ovalid_ff || out_ready;
   assign in_dmag = in_entry[N*AW+N +: DW];

   always_comb begin
      for (int k = 0; k < N; k++) begin
         in_num[k] = XW'(in_entry[k*AW +: AW]) << (2 * F);
      end
   end

   // stage 0: load and detect quotients of 2^(W-1) or more
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[0][k] <= in_num[k];
            quo_ff[0][k] <= '0;
            ovf_ff[0][k] <= in_num[k] >= (XW'(in_dmag) << (W - 1));
            neg_ff[0][k] <= in_entry[N*AW + k];
         end
         dmag_ff[0] <= in_dmag;
         sing_ff[0] <= in_entry[N*AW+N+DW];
         dval_ff[0] <= in_entry[N*AW+N+DW+1 +: W];
      end
   end

   // stages 1..W-1: quotient bit W-1-s
   for (genvar gs = 1; gs < W; gs++) begin : g_stage
      localparam int K = W - 1 - gs;
      logic [XW:0] trial [N];
      always_comb begin
         for (int k = 0; k < N; k++) begin
            trial[k] = {1'b0, rem_ff[gs-1][k]} - ((XW+1)'(dmag_ff[gs-1]) << K);
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int k = 0; k < N; k++) begin
               if (!trial[k][XW]) begin
                  rem_ff[gs][k] <= trial[k][XW-1:0];
                  quo_ff[gs][k] <= quo_ff[gs-1][k] | ((W-1)'(1) << K);
               end else begin
                  rem_ff[gs][k] <= rem_ff[gs-1][k];
                  quo_ff[gs][k] <= quo_ff[gs-1][k];
               end
               ovf_ff[gs][k] <= ovf_ff[gs-1][k];
               neg_ff[gs][k] <= neg_ff[gs-1][k];
            end
            dmag_ff[gs] <= dmag_ff[gs-1];
            sing_ff[gs] <= sing_ff[gs-1];
            dval_ff[gs] <= dval_ff[gs-1];
         end
      end
   end

   // output register: identity, saturation or signed quotient
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N; k++) begin
            if (sing_ff[W-1]) begin
               res_ff[k] <= (k % 4 == 0) ? ONE_VAL : '0;
            end else if (ovf_ff[W-1][k]) begin
               res_ff[k] <= neg_ff[W-1][k] ? MIN_VAL : MAX_VAL;
            end else if (neg_ff[W-1][k]) begin
               res_ff[k] <= W'(-{1'b0, quo_ff[W-1][k]});
            end else begin
               res_ff[k] <= {1'b0, quo_ff[W-1][k]};
            end
         end
         det_ff  <= dval_ff[W-1];
         sout_ff <= sing_ff[W-1];
      end
   end

   // valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         ovalid_ff <= 1'b0;
      end else if (advance) begin
         v_ff      <= {v_ff[W-2:0], in_valid};
         ovalid_ff <= v_ff[W-1];
      end
   end

   assign out_valid    = ovalid_ff;
   assign out_elems    = res_ff;
   assign out_det      = det_ff;
   assign out_singular = sout_ff;

endmodule

// ===== rtl/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 fixed-point matrix inverse by the adjugate
// One matrix per request, nine inverse elements plus determinant per response.
// ----------------------------------------------------------------------------
// Accepts one matrix per clock and returns one response per clock when the
// response side keeps up. A request passes through the determinant and
// cofactor stages, the queue, the bit-per-stage divider and one output
// register. A stalled response side fills the four-entry queue before
// req_tready drops. A determinant magnitude at or below singular_threshold
// (csr address 0) returns the identity with tuser set.
module matrix_inverse_3x3 #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // request: r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 from bit 0
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]       req_tdata,
   // response: r0c0 .. r2c2, det_value from bit 0
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((10*ELEMENT_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   // response tuser: singular
   output logic                                       rsp_tuser,
   // configuration
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [2:0]                                 csr_paddr,
   input  logic [31:0]                                csr_pwdata,
   output logic [31:0]                                csr_prdata,
   output logic                                       csr_pready
);

   localparam int W   = ELEMENT_WIDTH;
   localparam int N   = mi3_pkg::NUM_ELEMS;
   localparam int EW  = 9 * (2 * W + 1) + 9 + 3 * W + 3 + 1 + W;
   localparam int ODW = ((10 * W + 7) / 8) * 8;

   logic [30:0]   thr_ff, thr_in;
   logic          csr_wr;
   logic          front_adv, front_valid;
   logic [EW-1:0] front_entry, head_entry;
   logic          q_full, q_not_empty, back_adv;
   logic [W-1:0]  res_elems [N];
   logic [W-1:0]  res_det;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      thr_in = thr_ff;
      if (csr_wr && (csr_paddr[2] == mi3_pkg::REG_SINGULAR_THRESHOLD)) begin
         thr_in = csr_pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 31'd1;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == mi3_pkg::REG_SINGULAR_THRESHOLD) ?
                       {1'b0, thr_ff} : 32'd0;

   // front pipeline moves unless its last stage is blocked by a full queue
   assign front_adv  = !front_valid || !q_full;
   assign req_tready = front_adv;

   mi3_front #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (front_adv),
      .in_valid  (req_tvalid),
      .in_elems  (req_tdata[N*W-1:0]),
      .threshold (thr_ff),
      .out_valid (front_valid),
      .out_entry (front_entry)
   );

   mi3_queue #(
      .DATA_W (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (back_adv),
      .not_empty (q_not_empty),
      .head_data (head_entry)
   );

   mi3_back #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_not_empty),
      .in_entry     (head_entry),
      .advance      (back_adv),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_elems    (res_elems),
      .out_det      (res_det),
      .out_singular (rsp_tuser)
   );

   // response packing
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < N; k++) begin
         rsp_tdata[k*W +: W] = res_elems[k];
      end
      rsp_tdata[N*W +: W] = res_det;
   end

   // a singular response carries zeros in r0c1 and r1c0, off the diagonal
   a_sing_offdiag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[W +: W] == '0) &&
                                  (rsp_tdata[3*W +: W] == '0))
      else $error("singular response with nonzero off-diagonal element");

   // nothing leaves right after reset
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // a full queue holds the front still while its last stage is valid
   a_queue_hold: assert property (@(posedge clock) disable iff (reset)
      front_valid && q_full |-> !req_tready)
      else $error("request taken while front is blocked");

   // unused upper bits of the padded response stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >> (10 * W)) == ODW'(0)))
      else $error("response padding not zero");

endmodule
